/* rtl/base58_decode_to_bytes_defines.svh */
// Assertion macros for the base58 decoder.
// Used by the top level only; expects clk and arst_n in the including scope.
`ifndef BASE58_DECODE_TO_BYTES_DEFINES_SVH
`define BASE58_DECODE_TO_BYTES_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B58D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B58D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/b58d_pkg.sv */
// Shared types and constants of the base58 decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package b58d_pkg;

	localparam int OUT_BYTES   = 64;
	localparam int MAX_CHARS   = 88;
	localparam int RADIX       = 58;
	localparam int CHUNK_BYTES = 8;
	localparam int NUM_CHUNKS  = OUT_BYTES / CHUNK_BYTES;
	localparam int ACC_W       = OUT_BYTES * 8;
	localparam int CHUNK_W     = CHUNK_BYTES * 8;
	localparam int CHUNK_CNT_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int COUNT_W     = $clog2(MAX_CHARS + 2);
	localparam int DIGIT_W     = 6;
	localparam int IDX_W       = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [IDX_W-1:0] byte_index;
		logic             final_result;
		logic             invalid;
	} out_item_t;

	// Classified character as it travels from the front end to the back end.
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               err;
		logic               last;
	} q_entry_t;

	typedef struct packed {
		logic               valid;
		logic [DIGIT_W-1:0] value;
	} digit_t;

	// Maps a character byte to its digit value in the common alphabet.
	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t r;
		begin
			r.valid = 1'b1;
			if (c >= 8'h31 && c <= 8'h39) begin
				r.value = DIGIT_W'(c - 8'h31);
			end else if (c >= 8'h41 && c <= 8'h48) begin
				r.value = DIGIT_W'(c - 8'h41 + 8'd9);
			end else if (c >= 8'h4a && c <= 8'h4e) begin
				r.value = DIGIT_W'(c - 8'h4a + 8'd17);
			end else if (c >= 8'h50 && c <= 8'h5a) begin
				r.value = DIGIT_W'(c - 8'h50 + 8'd22);
			end else if (c >= 8'h61 && c <= 8'h6b) begin
				r.value = DIGIT_W'(c - 8'h61 + 8'd33);
			end else if (c >= 8'h6d && c <= 8'h7a) begin
				r.value = DIGIT_W'(c - 8'h6d + 8'd44);
			end else begin
				r.valid = 1'b0;
				r.value = '0;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/b58d_front.sv */
// Front end: accepts characters, maps them to digits and tracks string length.
// Depends on b58d_pkg.
`default_nettype none

module b58d_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire b58d_pkg::in_item_t in_data,
	input  wire logic               q_full,
	output logic                    push,
	output b58d_pkg::q_entry_t      push_entry
);

	logic [b58d_pkg::COUNT_W-1:0] count_q;
	logic [b58d_pkg::COUNT_W-1:0] count_next;
	b58d_pkg::digit_t             dig;
	logic                         too_long;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// The count saturates one above the limit.
	always_comb begin
		if (count_q <= b58d_pkg::COUNT_W'(b58d_pkg::MAX_CHARS)) begin
			count_next = count_q + 1'b1;
		end else begin
			count_next = count_q;
		end
		too_long = count_next > b58d_pkg::COUNT_W'(b58d_pkg::MAX_CHARS);
		dig      = b58d_pkg::digit_of(in_data.char_code);
		push_entry.digit = dig.value;
		push_entry.err   = too_long || !dig.valid;
		push_entry.last  = in_data.last_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= in_data.last_char ? '0 : count_next;
		end
	end

endmodule

`default_nettype wire

/* rtl/b58d_queue.sv */
// Short queue of classified characters between the front and back ends.
// Depends on b58d_pkg.
`default_nettype none

module b58d_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire b58d_pkg::q_entry_t push_entry,
	output logic                    full,
	input  wire logic               pop,
	output logic                    nonempty,
	output b58d_pkg::q_entry_t      head
);

	b58d_pkg::q_entry_t          slots_q [b58d_pkg::QUEUE_DEPTH];
	logic [b58d_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [b58d_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [b58d_pkg::QPTR_W:0]   fill_q;

	assign full     = fill_q == (b58d_pkg::QPTR_W + 1)'(b58d_pkg::QUEUE_DEPTH);
	assign nonempty = fill_q != '0;
	assign head     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/b58d_back.sv */
// Back end: multiply-accumulate over the 64-byte accumulator, then result output.
// Depends on b58d_pkg.
`default_nettype none

module b58d_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_nonempty,
	input  wire b58d_pkg::q_entry_t q_head,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output b58d_pkg::out_item_t     out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam int CARRY_W = 6;
	localparam int PROD_W  = 14;

	typedef struct packed {
		logic [b58d_pkg::CHUNK_W-1:0] word;
		logic [CARRY_W-1:0]           carry;
	} chunk_res_t;

	// Multiplies one chunk by the radix, least significant byte first.
	function automatic chunk_res_t mul_chunk(input logic [b58d_pkg::CHUNK_W-1:0] w,
	                                         input logic [CARRY_W-1:0] cin);
		chunk_res_t        r;
		logic [PROD_W-1:0] t;
		logic [CARRY_W-1:0] c;
		begin
			c = cin;
			for (int i = 0; i < b58d_pkg::CHUNK_BYTES; i++) begin
				t = PROD_W'(w[i*8 +: 8]) * PROD_W'(b58d_pkg::RADIX) + PROD_W'(c);
				r.word[i*8 +: 8] = t[7:0];
				c = t[8 +: CARRY_W];
			end
			r.carry = c;
			return r;
		end
	endfunction

	logic [1:0]                       state_q;
	logic [b58d_pkg::ACC_W-1:0]       acc_q;
	logic [CARRY_W-1:0]               carry_q;
	logic [b58d_pkg::CHUNK_CNT_W-1:0] chunk_q;
	logic                             last_q;
	logic                             error_q;
	logic [b58d_pkg::IDX_W-1:0]       emit_idx_q;
	logic                             out_valid_q;
	b58d_pkg::out_item_t              out_q;

	chunk_res_t mul;
	logic       mul_done;
	logic       err_eff;
	logic       slot_free;

	always_comb begin
		mul       = mul_chunk(acc_q[b58d_pkg::CHUNK_W-1:0], carry_q);
		mul_done  = (state_q == ST_MUL) &&
		            (chunk_q == b58d_pkg::CHUNK_CNT_W'(b58d_pkg::NUM_CHUNKS - 1));
		// A carry out of the top chunk is an overflow of the whole accumulator.
		err_eff   = error_q || (mul_done && (mul.carry != '0));
		slot_free = !out_valid_q || out_ready;
		q_pop     = q_nonempty && ((state_q == ST_IDLE) || (mul_done && !last_q));
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			carry_q     <= '0;
			chunk_q     <= '0;
			last_q      <= 1'b0;
			error_q     <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
				end
				ST_MUL: begin
					// The processed chunk rotates in at the top, so order is restored
					// after a full pass.
					acc_q   <= {mul.word, acc_q[b58d_pkg::ACC_W-1:b58d_pkg::CHUNK_W]};
					carry_q <= mul.carry;
					chunk_q <= chunk_q + 1'b1;
					if (mul_done) begin
						error_q <= err_eff;
						chunk_q <= '0;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (error_q) begin
							out_q.out_byte     <= '0;
							out_q.byte_index   <= '0;
							out_q.final_result <= 1'b1;
							out_q.invalid      <= 1'b1;
							acc_q              <= '0;
							error_q            <= 1'b0;
							state_q            <= ST_IDLE;
						end else begin
							out_q.out_byte     <= acc_q[b58d_pkg::ACC_W-1 -: 8];
							out_q.byte_index   <= emit_idx_q;
							out_q.final_result <=
								emit_idx_q == b58d_pkg::IDX_W'(b58d_pkg::OUT_BYTES - 1);
							out_q.invalid      <= 1'b0;
							// Shifting out bytes leaves the accumulator cleared at the end.
							acc_q      <= {acc_q[b58d_pkg::ACC_W-9:0], 8'h00};
							emit_idx_q <= emit_idx_q + 1'b1;
							if (emit_idx_q == b58d_pkg::IDX_W'(b58d_pkg::OUT_BYTES - 1)) begin
								emit_idx_q <= '0;
								state_q    <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (q_pop) begin
				if (err_eff || q_head.err) begin
					// After an error the rest of the string is only counted off.
					error_q <= 1'b1;
					state_q <= q_head.last ? ST_EMIT : ST_IDLE;
				end else begin
					carry_q <= q_head.digit;
					last_q  <= q_head.last;
					chunk_q <= '0;
					state_q <= ST_MUL;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/base58_decode_to_bytes.sv */
// Base58 text decoder producing a 64-byte big-endian value per string, top level.
// Depends on b58d_pkg, b58d_front, b58d_queue, b58d_back and the defines header.
//
// Characters arrive one item at a time; last_char marks the end of a string. Each
// valid character passes through the back end, where a single 8-byte slice
// multiplies the accumulator by 58 one chunk per cycle; the next character is taken
// from the queue while the last chunk is multiplied. A 4-entry queue lets the front
// end keep accepting items meanwhile. A string ends with 64 result items, most
// significant byte first, one per cycle while out_ready is high, or with a single
// item flagged invalid when the string was longer than 88 characters, held a
// character outside the alphabet or overflowed.
`default_nettype none
`include "base58_decode_to_bytes_defines.svh"

module base58_decode_to_bytes (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire b58d_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output b58d_pkg::out_item_t      out_data
);

	logic               q_full;
	logic               q_push;
	b58d_pkg::q_entry_t q_push_entry;
	logic               q_pop;
	logic               q_nonempty;
	b58d_pkg::q_entry_t q_head;

	b58d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	b58d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.nonempty   (q_nonempty),
		.head       (q_head)
	);

	b58d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	`B58D_ASSERT_NOW(a_pop_needs_entry, q_pop, q_nonempty, "pop from an empty queue")

	`B58D_ASSERT_NOW(a_invalid_is_single, out_valid && out_data.invalid,
		out_data.final_result && (out_data.out_byte == 8'h00),
		"invalid result is not a lone final item")

	`B58D_ASSERT_NOW(a_final_at_last_byte,
		out_valid && out_data.final_result && !out_data.invalid,
		out_data.byte_index == b58d_pkg::IDX_W'(b58d_pkg::OUT_BYTES - 1),
		"final result before the last byte")

	`B58D_ASSERT_NEXT(a_byte_order,
		out_valid && out_ready && !out_data.final_result && !out_data.invalid,
		!out_valid || (!out_data.invalid && (out_data.byte_index != 6'd0)),
		"byte sequence broken")

endmodule

`default_nettype wire

/* tb/base58_decode_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the base58 decoder: watches both item channels, decodes the
// accepted characters on its own and compares every result item in order.
// Depends on b58d_pkg for the item types and the size constants.
module base58_decode_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  b58d_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  b58d_pkg::out_item_t out_data,
	output int                  mismatches,
	output int                  pending,
	output int                  results_checked,
	output int                  strings_done,
	output int                  strings_invalid
);

	localparam logic [b58d_pkg::RADIX*8-1:0] DIGITS =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	// Decoder state for the string in progress.
	logic [b58d_pkg::ACC_W-1:0] acc_value = '0;
	int unsigned                chars_seen = 0;
	logic                       string_bad = 1'b0;
	b58d_pkg::out_item_t        expected_bytes[$];

	function automatic int digit_value(input logic [7:0] c);
		for (int i = 0; i < b58d_pkg::RADIX; i++) begin
			if (DIGITS[(b58d_pkg::RADIX-1-i)*8 +: 8] == c) begin
				return i;
			end
		end
		return -1;
	endfunction

	task automatic take_char(input b58d_pkg::in_item_t item);
		int                           d;
		logic [b58d_pkg::ACC_W+7:0]   product;
		b58d_pkg::out_item_t          r;
		if (chars_seen <= b58d_pkg::MAX_CHARS) begin
			chars_seen++;
		end
		if (chars_seen > b58d_pkg::MAX_CHARS) begin
			string_bad = 1'b1;
		end
		if (!string_bad) begin
			d = digit_value(item.char_code);
			if (d < 0) begin
				string_bad = 1'b1;
			end else begin
				product = {8'd0, acc_value};
				product = product * b58d_pkg::RADIX + d;
				acc_value = product[b58d_pkg::ACC_W-1:0];
				// Anything left above the top byte means the value no longer fits.
				if (product[b58d_pkg::ACC_W+7:b58d_pkg::ACC_W] != 8'd0) begin
					string_bad = 1'b1;
				end
			end
		end
		if (item.last_char) begin
			if (string_bad) begin
				r.out_byte = 8'd0;
				r.byte_index = '0;
				r.final_result = 1'b1;
				r.invalid = 1'b1;
				expected_bytes.push_back(r);
				strings_invalid++;
			end else begin
				for (int k = 0; k < b58d_pkg::OUT_BYTES; k++) begin
					r.out_byte = acc_value[b58d_pkg::ACC_W-1-8*k -: 8];
					r.byte_index = b58d_pkg::IDX_W'(k);
					r.final_result = (k == b58d_pkg::OUT_BYTES - 1);
					r.invalid = 1'b0;
					expected_bytes.push_back(r);
				end
			end
			strings_done++;
			acc_value = '0;
			chars_seen = 0;
			string_bad = 1'b0;
		end
	endtask

	task automatic check_result(input b58d_pkg::out_item_t got);
		b58d_pkg::out_item_t want;
		results_checked++;
		if (expected_bytes.size() == 0) begin
			mismatches++;
			$error("result item with nothing expected: out_byte %0d byte_index %0d",
				got.out_byte, got.byte_index);
		end else begin
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				mismatches++;
				$error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
			end
			if (got.byte_index !== want.byte_index) begin
				mismatches++;
				$error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
			end
			if (got.final_result !== want.final_result) begin
				mismatches++;
				$error("final_result: expected %0d, got %0d", want.final_result,
					got.final_result);
			end
			if (got.invalid !== want.invalid) begin
				mismatches++;
				$error("invalid: expected %0d, got %0d", want.invalid, got.invalid);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				check_result(out_data);
			end
			if (in_valid && in_ready) begin
				take_char(in_data);
			end
			pending = expected_bytes.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the base58 decoder testbench: clock, reset, character stimulus and
// output back-pressure. Depends on b58d_pkg, base58_decode_to_bytes and
// base58_decode_checker.
module testbench;

	localparam logic [b58d_pkg::RADIX*8-1:0] DIGITS =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
	localparam int PHASE_ITEMS = 140;
	localparam int HOLD_CYCLES = 2000;

	typedef enum int {
		STR_SHORT,
		STR_MEDIUM,
		STR_BAD_CHAR,
		STR_NOISE,
		STR_FULL_LENGTH,
		STR_TOO_LONG,
		STR_OVERFLOW
	} string_kind_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	b58d_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	b58d_pkg::out_item_t out_data;

	int mismatches, pending, results_checked, strings_done, strings_invalid;
	int items_sent = 0;
	int send_idle_pct = 27;
	int recv_idle_pct = 54;
	int idle_phase = 0;
	logic long_hold_done = 1'b0;

	always #1 clk = ~clk;

	base58_decode_to_bytes u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	base58_decode_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_checked(results_checked),
		.strings_done   (strings_done),
		.strings_invalid(strings_invalid)
	);

	function automatic logic [7:0] pick_digit();
		return DIGITS[(b58d_pkg::RADIX-1-$urandom_range(0, b58d_pkg::RADIX-1))*8 +: 8];
	endfunction

	// Any byte that is not part of the alphabet, including the look-alike letters.
	function automatic logic [7:0] pick_non_digit();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(8'h00, 8'h30));
			1: return 8'($urandom_range(8'h3a, 8'h40));
			2: begin
				case ($urandom_range(0, 2))
					0: return "I";
					1: return "O";
					default: return "l";
				endcase
			end
			3: return 8'($urandom_range(8'h5b, 8'h60));
			default: return 8'($urandom_range(8'h7b, 8'hff));
		endcase
	endfunction

	// Called at a rising edge; returns at the rising edge where the item was taken.
	task automatic send_item(input logic [7:0] c, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{char_code: c, last_char: last};
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], i == s.len() - 1);
		end
	endtask

	task automatic send_string(input string_kind_t kind);
		int         len;
		int         lead_ones;
		int         bad_pos;
		logic [7:0] c;
		lead_ones = 0;
		bad_pos = -1;
		case (kind)
			STR_SHORT: begin
				len = $urandom_range(1, 12);
				if ($urandom_range(0, 2) == 0) begin
					lead_ones = $urandom_range(1, len);
				end
			end
			STR_MEDIUM: len = $urandom_range(20, 45);
			STR_BAD_CHAR: begin
				len = $urandom_range(1, 10);
				bad_pos = $urandom_range(0, len - 1);
			end
			STR_NOISE: len = $urandom_range(1, 4);
			// A leading one keeps 88 digits inside 64 bytes.
			STR_FULL_LENGTH: begin
				len = b58d_pkg::MAX_CHARS;
				lead_ones = 1;
			end
			STR_TOO_LONG: begin
				len = $urandom_range(b58d_pkg::MAX_CHARS + 1, b58d_pkg::MAX_CHARS + 3);
				lead_ones = 1;
			end
			default: len = b58d_pkg::MAX_CHARS;
		endcase
		for (int i = 0; i < len; i++) begin
			if (i < lead_ones) begin
				c = "1";
			end else if (i == bad_pos) begin
				c = pick_non_digit();
			end else if (kind == STR_NOISE) begin
				c = 8'($urandom_range(0, 255));
			end else if (kind == STR_OVERFLOW && i == 0) begin
				c = "z";
			end else begin
				c = pick_digit();
			end
			send_item(c, i == len - 1);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// Receiver: random back-pressure, plus one long hold-off at the start of the
	// last phase so that the decoder backs up into its input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_phase == 2 && !long_hold_done) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int           phase_end;
		int           pick;
		string_kind_t kind;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero, the largest single digit, leading ones, a first multiplication by the
		// radix and the edges of every alphabet range.
		send_text("1");
		send_text("z");
		send_text("112");
		send_text("21");
		send_text("9AHJNPZakmz");
		// Bad characters: alone, in the middle with ignored characters after
		// it, and the letters left out of the alphabet.
		send_item(8'h00, 1'b1);
		send_item("3", 1'b0);
		send_item(8'hff, 1'b0);
		send_item("4", 1'b1);
		send_text("l");
		send_text("IO");
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 54;
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			idle_phase = phase;
			phase_end = items_sent + PHASE_ITEMS;
			case (phase)
				0: send_string(STR_TOO_LONG);
				1: send_string(STR_OVERFLOW);
				default: send_string(STR_FULL_LENGTH);
			endcase
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					kind = STR_SHORT;
				end else if (pick < 72) begin
					kind = STR_MEDIUM;
				end else if (pick < 86) begin
					kind = STR_BAD_CHAR;
				end else begin
					kind = STR_NOISE;
				end
				send_string(kind);
			end
			drain_results();
		end

		repeat (200) @(posedge clk);
		$display("Sent %0d characters in %0d strings, %0d of them rejected as invalid.",
			items_sent, strings_done, strings_invalid);
		$display("Compared %0d result items under three back-pressure mixes.",
			results_checked);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/b58d_pkg.sv
rtl/b58d_front.sv
rtl/b58d_queue.sv
rtl/b58d_back.sv
rtl/base58_decode_to_bytes.sv
tb/base58_decode_checker.sv
tb/testbench.sv
